FILE: rtl/kvrt_pkg.sv
// Shared types and constants for the key/value record tokenizer.
package kvrt_pkg;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 8;
  localparam int LEN_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_EQUALS_CHAR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EQUALS_EN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_CHAR = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_EN = 8'd3;

  localparam logic [2:0] KIND_KEY = 3'd0;
  localparam logic [2:0] KIND_VALUE = 3'd1;
  localparam logic [2:0] KIND_PAIR = 3'd2;
  localparam logic [2:0] KIND_RECORD = 3'd3;
  localparam logic [2:0] KIND_ERROR = 3'd4;

  localparam logic [1:0] PH_KEY = 2'd0;
  localparam logic [1:0] PH_VALUE = 2'd1;
  localparam logic [1:0] PH_DISCARD = 2'd2;

  localparam logic [7:0] CHAR_QUOTE = 8'd34;
  localparam logic [7:0] CHAR_NUL = 8'd0;
  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_CR = 8'd13;

  localparam logic [7:0] EQUALS_RESET = 8'd61;
  localparam logic [7:0] SEP_RESET = 8'd59;

  typedef struct packed {
    logic [7:0] equals_char;
    logic       equals_en;
    logic [7:0] sep_char;
    logic       sep_en;
  } cfg_t;

endpackage

FILE: rtl/key_value_record_tokenizer.sv
// Key/value record tokenizer top level: one raw character in, at most one tagged token out.
//
// The input channel (in_valid, in_stall, in_byte) takes one raw character per
// transfer. The result channel (out_valid, out_stall, out_kind, out_byte)
// carries tokens: key or value characters, pair end, record end or error.
// Characters that only change state (quotes, the equals character, bytes in
// discard) make no output transfer.
// Each accepted character is classified in the cycle it is taken and its
// token sits in the output register from the next cycle; the block takes
// one character per clock cycle while in_stall is low.
// in_stall rises only while a token waits in the output register and the
// receiver stalls; a new character is taken in the same cycle the waiting
// token leaves.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; writes to indexes beyond three are dropped.
// Synchronous reset restores the register defaults, key phase, the unquoted
// state, a zero field length and an empty output register.
module key_value_record_tokenizer
  import kvrt_pkg::*;
#(
  parameter int KEY_MAX = 64,
  parameter int VALUE_MAX = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_kind,
  output logic [7:0]            out_byte,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t             cfg_r;
  logic [1:0]       phase_r, phase_nxt;
  logic             quoted_r, quoted_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             out_valid_r;
  logic [2:0]       out_kind_r;
  logic [7:0]       out_byte_r;

  logic             in_acc;
  logic             is_end;
  logic [LEN_W-1:0] limit;
  logic             res_vld;
  logic [2:0]       res_kind;
  logic [7:0]       res_byte;

  assign in_stall = out_valid_r & out_stall;
  assign in_acc = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_byte = out_byte_r;

  assign is_end = (in_byte == CHAR_NUL) || (in_byte == CHAR_LF) || (in_byte == CHAR_CR);
  assign limit = (phase_r == PH_KEY) ? LEN_W'(KEY_MAX) : LEN_W'(VALUE_MAX);

  always_comb begin
    phase_nxt = phase_r;
    quoted_nxt = quoted_r;
    len_nxt = len_r;
    res_vld = 1'b0;
    res_kind = KIND_KEY;
    res_byte = 8'd0;
    if (in_acc) begin
      priority if (phase_r != PH_KEY && phase_r != PH_VALUE) begin
        if (is_end) begin
          phase_nxt = PH_KEY;
          quoted_nxt = 1'b0;
          len_nxt = '0;
        end
      end else if (len_r >= limit) begin
        quoted_nxt = 1'b0;
        len_nxt = '0;
        phase_nxt = is_end ? PH_KEY : PH_DISCARD;
        res_vld = 1'b1;
        res_kind = KIND_ERROR;
      end else begin
        len_nxt = len_r + LEN_W'(1);
        priority if (in_byte == CHAR_QUOTE) begin
          quoted_nxt = ~quoted_r;
        end else if (!quoted_r && is_end) begin
          phase_nxt = PH_KEY;
          len_nxt = '0;
          res_vld = 1'b1;
          res_kind = KIND_RECORD;
        end else if (!quoted_r && phase_r == PH_KEY && cfg_r.equals_en &&
                     in_byte == cfg_r.equals_char) begin
          phase_nxt = PH_VALUE;
          len_nxt = '0;
        end else if (!quoted_r && cfg_r.sep_en && in_byte == cfg_r.sep_char) begin
          phase_nxt = PH_KEY;
          len_nxt = '0;
          res_vld = 1'b1;
          res_kind = KIND_PAIR;
        end else begin
          res_vld = 1'b1;
          res_kind = (phase_r == PH_KEY) ? KIND_KEY : KIND_VALUE;
          res_byte = in_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.equals_char <= EQUALS_RESET;
      cfg_r.equals_en <= 1'b1;
      cfg_r.sep_char <= SEP_RESET;
      cfg_r.sep_en <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_EQUALS_CHAR: cfg_r.equals_char <= cfg_data[7:0];
        CFG_EQUALS_EN:   cfg_r.equals_en <= cfg_data[0];
        CFG_SEP_CHAR:    cfg_r.sep_char <= cfg_data[7:0];
        CFG_SEP_EN:      cfg_r.sep_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_KEY;
      quoted_r <= 1'b0;
      len_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      quoted_r <= quoted_nxt;
      len_r <= len_nxt;
      if (res_vld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_kind_r <= res_kind;
      out_byte_r <= res_byte;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DISCARD |-> !quoted_r)
    else $error("Quoted mode is set while discarding.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_KEY |-> len_r <= LEN_W'(KEY_MAX)) and
    (phase_r == PH_VALUE |-> len_r <= LEN_W'(VALUE_MAX)))
    else $error("Field length ran past its limit.");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_r == PH_DISCARD |=> !out_valid)
    else $error("A discarded character produced a token.");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_KEY && out_kind != KIND_VALUE |-> out_byte == 8'd0)
    else $error("A control token carries a nonzero byte.");

  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3)
    else $error("Phase holds the unused code.");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the key/value record tokenizer.
`timescale 1ns / 1ps

module testbench;
  import kvrt_pkg::*;

  localparam int KEY_LIMIT = 64;
  localparam int VALUE_LIMIT = 64;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT = 500000;
  localparam int CHARS_PER_PHASE = 120;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } token_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            out_kind;
  logic [7:0]            out_byte;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [7:0] char_q[$];
  token_t     token_q[$];
  token_t     want;
  int         chars_sent = 0;
  int         errors = 0;
  int         cycles = 0;
  bit         in_taken = 1'b0;
  bit         in_quiet = 1'b0;
  bit         out_quiet = 1'b0;
  int         in_wait = 0;
  int         out_wait = 0;

  logic [1:0]       tk_phase = PH_KEY;
  logic             tk_quoted = 1'b0;
  logic [LEN_W-1:0] tk_len = '0;
  cfg_t             tk_cfg = '{EQUALS_RESET, 1'b1, SEP_RESET, 1'b1};

  key_value_record_tokenizer #(
    .KEY_MAX(KEY_LIMIT),
    .VALUE_MAX(VALUE_LIMIT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_byte(out_byte),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit is_terminator(logic [7:0] c);
    return c == CHAR_NUL || c == CHAR_LF || c == CHAR_CR;
  endfunction

  function automatic void tokenize(logic [7:0] c);
    int lim;
    if (tk_phase != PH_KEY && tk_phase != PH_VALUE) begin
      if (is_terminator(c)) begin
        tk_phase = PH_KEY;
        tk_quoted = 1'b0;
        tk_len = '0;
      end
      return;
    end
    lim = (tk_phase == PH_KEY) ? KEY_LIMIT : VALUE_LIMIT;
    if (tk_len >= lim) begin
      tk_quoted = 1'b0;
      tk_len = '0;
      tk_phase = is_terminator(c) ? PH_KEY : PH_DISCARD;
      token_q.push_back(token_t'{KIND_ERROR, 8'h00});
      return;
    end
    tk_len = tk_len + 1'b1;
    if (c == CHAR_QUOTE) begin
      tk_quoted = ~tk_quoted;
      return;
    end
    if (!tk_quoted) begin
      if (is_terminator(c)) begin
        tk_phase = PH_KEY;
        tk_len = '0;
        token_q.push_back(token_t'{KIND_RECORD, 8'h00});
        return;
      end
      if (tk_phase == PH_KEY && tk_cfg.equals_en && c == tk_cfg.equals_char) begin
        tk_phase = PH_VALUE;
        tk_len = '0;
        return;
      end
      if (tk_cfg.sep_en && c == tk_cfg.sep_char) begin
        tk_phase = PH_KEY;
        tk_len = '0;
        token_q.push_back(token_t'{KIND_PAIR, 8'h00});
        return;
      end
    end
    token_q.push_back(token_t'{(tk_phase == PH_KEY) ? KIND_KEY : KIND_VALUE, c});
  endfunction

  function automatic int idle_len(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
        if (in_wait > 0) begin
          in_valid <= 1'b0;
          in_wait--;
        end else if (char_q.size() != 0) begin
          in_valid <= 1'b1;
          in_byte <= char_q.pop_front();
          in_wait = idle_len(in_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
      if (out_wait > 0) begin
        out_stall <= 1'b1;
        out_wait--;
      end else begin
        out_stall <= 1'b0;
        out_wait = idle_len(out_quiet);
      end
    end
  end

  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) tokenize(in_byte);
    if (rst_n && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        $error("unexpected transfer: kind %0d, out_byte %0h", out_kind, out_byte);
        errors++;
      end else begin
        want = token_q.pop_front();
        if (out_kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_kind);
          errors++;
        end
        if (out_byte !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, out_byte);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_char(logic [7:0] c);
    char_q.push_back(c);
    chars_sent++;
  endtask

  task automatic push_text(string s);
    foreach (s[i]) push_char(s[i]);
  endtask

  function automatic logic [7:0] end_char();
    case ($urandom_range(0, 2))
      0: return CHAR_NUL;
      1: return CHAR_LF;
      default: return CHAR_CR;
    endcase
  endfunction

  function automatic logic [7:0] field_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'($urandom_range(97, 122));
    if (r < 70) return 8'($urandom);
    if (r < 78) return CHAR_QUOTE;
    if (r < 84) return tk_cfg.equals_char;
    if (r < 88) return tk_cfg.sep_char;
    if (r < 91) return end_char();
    return 8'($urandom_range(48, 57));
  endfunction

  function automatic int field_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, 8);
    if (r < 95) return $urandom_range(9, 40);
    return $urandom_range(60, 70);
  endfunction

  task automatic push_field(int n);
    repeat (n) push_char(field_char());
  endtask

  task automatic push_letters(int n);
    repeat (n) push_char(8'($urandom_range(97, 122)));
  endtask

  task automatic push_record();
    int pairs;
    int r;
    pairs = $urandom_range(1, 4);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 6)) push_char(8'($urandom));
      return;
    end
    if (r < 14) begin
      if (r % 2) begin
        push_letters(1);
        push_char(tk_cfg.equals_char);
        push_letters(VALUE_LIMIT);
      end else begin
        push_letters(KEY_LIMIT);
      end
      if ($urandom_range(0, 1)) push_field($urandom_range(1, 5));
      push_char(end_char());
      return;
    end
    for (int p = 0; p < pairs; p++) begin
      push_field(field_len());
      if ($urandom_range(0, 3) != 0) begin
        push_char(tk_cfg.equals_char);
        push_field(field_len());
      end
      if (p < pairs - 1) push_char(tk_cfg.sep_char);
    end
    if ($urandom_range(0, 19) != 0) push_char(end_char());
  endtask

  task automatic settle();
    while (char_q.size() != 0 || in_valid || token_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_EQUALS_CHAR: tk_cfg.equals_char = data;
      CFG_EQUALS_EN: tk_cfg.equals_en = data[0];
      CFG_SEP_CHAR: tk_cfg.sep_char = data;
      CFG_SEP_EN: tk_cfg.sep_en = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic [7:0] eq, logic eq_en, logic [7:0] sep, logic sep_en);
    write_reg(CFG_EQUALS_CHAR, eq);
    write_reg(CFG_EQUALS_EN, CFG_DATA_W'(eq_en));
    write_reg(CFG_SEP_CHAR, sep);
    write_reg(CFG_SEP_EN, CFG_DATA_W'(sep_en));
  endtask

  task automatic run_random(int n);
    int target;
    target = chars_sent + n;
    while (chars_sent < target) push_record();
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_text("k=v=;");
    push_text("\"a;b\"");
    push_char(8'hFF);
    push_char(8'h80);
    push_text("=x");
    push_char(CHAR_LF);
    push_text("k=");
    push_char(CHAR_CR);
    push_char(CHAR_NUL);
    push_char(CHAR_QUOTE);
    push_char(CHAR_LF);
    push_char(CHAR_QUOTE);
    push_char(CHAR_CR);
    settle();
    run_random(CHARS_PER_PHASE);

    set_config(8'h00, 1'b0, 8'hFF, 1'b1);
    run_random(CHARS_PER_PHASE);
    set_config(8'hFF, 1'b1, 8'h00, 1'b0);
    run_random(CHARS_PER_PHASE);
    set_config(":", 1'b1, ",", 1'b1);
    write_reg(CFG_SEP_EN + CFG_IDX_W'($urandom_range(1, 252)), 8'($urandom));
    run_random(CHARS_PER_PHASE);
    set_config(CHAR_QUOTE, 1'b1, CHAR_LF, 1'b1);
    run_random(CHARS_PER_PHASE);
    set_config(EQUALS_RESET, 1'b1, EQUALS_RESET, 1'b1);
    run_random(CHARS_PER_PHASE);
    repeat (2) begin
      set_config(8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
      run_random(CHARS_PER_PHASE);
    end

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: key_value_record_tokenizer.f
rtl/kvrt_pkg.sv
rtl/key_value_record_tokenizer.sv
dv/testbench.sv
